// File: rtl/cdow_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and calendar functions for the date offset and weekday block.
package cdow_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int R400_W  = 9;
    localparam int CENT_W  = 7;
    localparam int WSUM_W  = 9;
    localparam int ZTERM_W = 6;
    localparam int UPC_W   = 4;

    localparam logic [YEAR_W-1:0]  YEAR_DEFAULT     = 14'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_MAX         = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEARS_PER_CYCLE  = 14'd400;
    localparam logic [YEAR_W-1:0]  YEARS_PER_CENT   = 14'd100;
    localparam logic [R400_W-1:0]  R400_DEFAULT     = 9'd300;
    localparam logic [R400_W-1:0]  R400_LAST        = 9'd399;
    localparam logic [R400_W-1:0]  R400_CENT1       = 9'd100;
    localparam logic [R400_W-1:0]  R400_CENT2       = 9'd200;
    localparam logic [R400_W-1:0]  R400_CENT3       = 9'd300;
    localparam logic [MONTH_W-1:0] MONTH_JAN        = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB        = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC        = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST        = 5'd1;
    localparam logic [DAY_W-1:0]   FEB_DAYS         = 5'd28;
    localparam logic [DAY_W-1:0]   FEB_DAYS_LEAP    = 5'd29;
    localparam logic [WDAY_W-1:0]  WDAY_MONDAY      = 3'd1;
    localparam logic [WSUM_W-1:0]  DAYS_PER_WEEK    = 9'd7;
    localparam logic [WSUM_W-1:0]  WEEK_BIAS        = 9'd210;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SUB400,
        OP_SET_LEAP,
        OP_CHECK,
        OP_ADD_OFF,
        OP_FWD,
        OP_BWD,
        OP_RANGE,
        OP_ZPREP,
        OP_SUB100,
        OP_ZSUM1,
        OP_ZSUM2,
        OP_SUB7,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_T_GE400,
        C_S_GT_MLEN,
        C_S_LT1,
        C_T_GE100,
        C_W_GE7,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic no_in;
        logic t_ge400;
        logic s_gt_mlen;
        logic s_lt1;
        logic t_ge100;
        logic w_ge7;
        logic out_free;
    } status_t;

    typedef struct packed {
        op_t  op;
        logic idle;
    } ctrl_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                 len = leap ? FEB_DAYS_LEAP : FEB_DAYS;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:              len = 5'd31;
        endcase
        return len;
    endfunction

    // Month term of the congruence, 26 * (m + 1) / 10, for shifted months 3 to 14.
    function automatic logic [ZTERM_W-1:0] zeller_term(input logic [MONTH_W-1:0] zm);
        logic [ZTERM_W-1:0] v;
        case (zm)
            4'd3:    v = 6'd10;
            4'd4:    v = 6'd13;
            4'd5:    v = 6'd15;
            4'd6:    v = 6'd18;
            4'd7:    v = 6'd20;
            4'd8:    v = 6'd23;
            4'd9:    v = 6'd26;
            4'd10:   v = 6'd28;
            4'd11:   v = 6'd31;
            4'd12:   v = 6'd33;
            4'd13:   v = 6'd36;
            4'd14:   v = 6'd39;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/calendar_date_offset_weekday.sv
`timescale 1ns / 1ps
// Top level: Gregorian date plus signed day offset, with leap flag and weekday.
//
// Input channel: in_valid and in_stall; a transfer carries in_year, in_month,
// in_day and a signed day_offset. Output channel: out_valid and out_stall; a
// transfer carries the resulting date, is_leap_year, weekday (0 is Sunday)
// and range_error. A start date with year 0, month outside 1 to 12, day 0 or
// a February day past the month's end is replaced by 1900-01-01, and a result
// year outside 1 to 9999 returns 1900-01-01 with range_error set. One item
// is processed at a time by a microcoded sequencer stepping a small
// datapath; the month walk, one month per cycle, dominates its run time.
// in_stall is low only while the sequencer waits at its first step. The
// finished result sits in an output register; a new input transfer is taken
// while it waits, and the next result waits at the emit and retry steps
// until the receiver drops out_stall. Reset returns the sequencer to its
// first step and clears out_valid.
module calendar_date_offset_weekday
#(
    parameter int OFFSET_BITS = cdow_pkg::OFFSET_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cdow_pkg::YEAR_W-1:0]        in_year,
    input  logic [cdow_pkg::MONTH_W-1:0]       in_month,
    input  logic [cdow_pkg::DAY_W-1:0]         in_day,
    input  logic signed [OFFSET_BITS-1:0]      day_offset,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cdow_pkg::YEAR_W-1:0]        out_year,
    output logic [cdow_pkg::MONTH_W-1:0]       out_month,
    output logic [cdow_pkg::DAY_W-1:0]         out_day,
    output logic                               is_leap_year,
    output logic [cdow_pkg::WDAY_W-1:0]        weekday,
    output logic                               range_error
);

    localparam int YW = (((OFFSET_BITS - 9) > cdow_pkg::YEAR_W) ?
                         (OFFSET_BITS - 9) : cdow_pkg::YEAR_W) + 2;
    localparam int SW = OFFSET_BITS + 1;
    localparam int WX = cdow_pkg::WSUM_W + 1;

    cdow_pkg::status_t status;
    cdow_pkg::ctrl_t   ctrl;

    cdow_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    logic signed [YW-1:0]              y_reg, y_next;
    logic [cdow_pkg::MONTH_W-1:0]      m_reg, m_next;
    logic signed [SW-1:0]              s_reg, s_next;
    logic signed [OFFSET_BITS-1:0]     off_reg, off_next;
    logic [cdow_pkg::YEAR_W-1:0]       t_reg, t_next;
    logic [cdow_pkg::CENT_W-1:0]       q_reg, q_next;
    logic [cdow_pkg::MONTH_W-1:0]      zm_reg, zm_next;
    logic [cdow_pkg::WSUM_W-1:0]       w_reg, w_next;
    logic [cdow_pkg::R400_W-1:0]       r400_reg, r400_next;
    logic                              err_reg, err_next;

    logic                              out_valid_reg, out_valid_next;
    logic [cdow_pkg::YEAR_W-1:0]       out_year_reg;
    logic [cdow_pkg::MONTH_W-1:0]      out_month_reg;
    logic [cdow_pkg::DAY_W-1:0]        out_day_reg;
    logic                              out_leap_reg;
    logic [cdow_pkg::WDAY_W-1:0]       out_wday_reg;
    logic                              out_err_reg;

    logic                              leap;
    logic [cdow_pkg::DAY_W-1:0]        mlen;
    logic [cdow_pkg::MONTH_W-1:0]      m_prev;
    logic [cdow_pkg::DAY_W-1:0]        mlen_prev;
    logic [cdow_pkg::DAY_W-1:0]        feb_max;
    logic                              start_bad;
    logic                              year_bad;
    logic                              early;
    logic                              out_free;
    logic                              emit;
    logic [WX-1:0]                     zsum1;
    logic [WX-1:0]                     zsum2;

    always_comb
    begin
        leap = (r400_reg[1:0] == 2'b00) && (r400_reg != cdow_pkg::R400_CENT1) &&
               (r400_reg != cdow_pkg::R400_CENT2) && (r400_reg != cdow_pkg::R400_CENT3);
        mlen      = cdow_pkg::month_len(m_reg, leap);
        m_prev    = (m_reg == cdow_pkg::MONTH_JAN) ? cdow_pkg::MONTH_DEC : m_reg - 4'd1;
        mlen_prev = cdow_pkg::month_len(m_prev, leap);
        feb_max   = leap ? cdow_pkg::FEB_DAYS_LEAP : cdow_pkg::FEB_DAYS;
        start_bad = (y_reg == '0) || (m_reg == '0) || (m_reg > cdow_pkg::MONTH_DEC) ||
                    (s_reg[cdow_pkg::DAY_W-1:0] == '0) ||
                    ((m_reg == cdow_pkg::MONTH_FEB) && (s_reg[cdow_pkg::DAY_W-1:0] > feb_max));
        year_bad  = (y_reg < $signed(YW'(1))) ||
                    (y_reg > $signed(YW'(cdow_pkg::YEAR_MAX)));
        early     = (m_reg <= cdow_pkg::MONTH_FEB);
        out_free  = !out_valid_reg || !out_stall;
        emit      = (ctrl.op == cdow_pkg::OP_EMIT) && out_free;
        zsum1     = WX'(t_reg[cdow_pkg::CENT_W-1:0]) + WX'(t_reg[cdow_pkg::CENT_W-1:2]) +
                    WX'(q_reg[cdow_pkg::CENT_W-1:2]) + WX'(cdow_pkg::WEEK_BIAS) -
                    WX'({q_reg, 1'b0});
        zsum2     = WX'(w_reg) + WX'(cdow_pkg::zeller_term(zm_reg)) +
                    WX'(s_reg[cdow_pkg::DAY_W-1:0]) - WX'(1);

        status.no_in     = !in_valid;
        status.t_ge400   = (t_reg >= cdow_pkg::YEARS_PER_CYCLE);
        status.s_gt_mlen = (s_reg > $signed(SW'(mlen)));
        status.s_lt1     = (s_reg < $signed(SW'(1)));
        status.t_ge100   = (t_reg >= cdow_pkg::YEARS_PER_CENT);
        status.w_ge7     = (w_reg >= cdow_pkg::DAYS_PER_WEEK);
        status.out_free  = out_free;
    end

    always_comb
    begin
        y_next    = y_reg;
        m_next    = m_reg;
        s_next    = s_reg;
        off_next  = off_reg;
        t_next    = t_reg;
        q_next    = q_reg;
        zm_next   = zm_reg;
        w_next    = w_reg;
        r400_next = r400_reg;
        err_next  = err_reg;
        case (ctrl.op)
            cdow_pkg::OP_LOAD:
            begin
                y_next   = YW'(in_year);
                m_next   = in_month;
                s_next   = SW'(in_day);
                off_next = day_offset;
                t_next   = in_year;
            end
            cdow_pkg::OP_SUB400:
            begin
                if (status.t_ge400)
                begin
                    t_next = t_reg - cdow_pkg::YEARS_PER_CYCLE;
                end
            end
            cdow_pkg::OP_SET_LEAP:
            begin
                r400_next = t_reg[cdow_pkg::R400_W-1:0];
            end
            cdow_pkg::OP_CHECK:
            begin
                if (start_bad)
                begin
                    y_next    = YW'(cdow_pkg::YEAR_DEFAULT);
                    m_next    = cdow_pkg::MONTH_JAN;
                    s_next    = SW'(cdow_pkg::DAY_FIRST);
                    r400_next = cdow_pkg::R400_DEFAULT;
                end
            end
            cdow_pkg::OP_ADD_OFF:
            begin
                s_next = s_reg + SW'(off_reg);
            end
            cdow_pkg::OP_FWD:
            begin
                if (status.s_gt_mlen)
                begin
                    s_next = s_reg - $signed(SW'(mlen));
                    if (m_reg == cdow_pkg::MONTH_DEC)
                    begin
                        m_next    = cdow_pkg::MONTH_JAN;
                        y_next    = y_reg + $signed(YW'(1));
                        r400_next = (r400_reg == cdow_pkg::R400_LAST) ? '0 : r400_reg + 9'd1;
                    end
                    else
                    begin
                        m_next = m_reg + 4'd1;
                    end
                end
            end
            cdow_pkg::OP_BWD:
            begin
                if (status.s_lt1)
                begin
                    m_next = m_prev;
                    s_next = s_reg + $signed(SW'(mlen_prev));
                    if (m_reg == cdow_pkg::MONTH_JAN)
                    begin
                        y_next    = y_reg - $signed(YW'(1));
                        r400_next = (r400_reg == '0) ? cdow_pkg::R400_LAST : r400_reg - 9'd1;
                    end
                end
            end
            cdow_pkg::OP_RANGE:
            begin
                err_next = year_bad;
                if (year_bad)
                begin
                    y_next    = YW'(cdow_pkg::YEAR_DEFAULT);
                    m_next    = cdow_pkg::MONTH_JAN;
                    s_next    = SW'(cdow_pkg::DAY_FIRST);
                    r400_next = cdow_pkg::R400_DEFAULT;
                end
            end
            cdow_pkg::OP_ZPREP:
            begin
                t_next  = early ? cdow_pkg::YEAR_W'(y_reg - $signed(YW'(1))) :
                                  cdow_pkg::YEAR_W'(y_reg);
                q_next  = '0;
                zm_next = early ? m_reg + cdow_pkg::MONTH_DEC : m_reg;
            end
            cdow_pkg::OP_SUB100:
            begin
                if (status.t_ge100)
                begin
                    t_next = t_reg - cdow_pkg::YEARS_PER_CENT;
                    q_next = q_reg + 7'd1;
                end
            end
            cdow_pkg::OP_ZSUM1:
            begin
                w_next = zsum1[cdow_pkg::WSUM_W-1:0];
            end
            cdow_pkg::OP_ZSUM2:
            begin
                w_next = zsum2[cdow_pkg::WSUM_W-1:0];
            end
            cdow_pkg::OP_SUB7:
            begin
                if (status.w_ge7)
                begin
                    w_next = w_reg - cdow_pkg::DAYS_PER_WEEK;
                end
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        m_reg    <= m_next;
        s_reg    <= s_next;
        off_reg  <= off_next;
        t_reg    <= t_next;
        q_reg    <= q_next;
        zm_reg   <= zm_next;
        w_reg    <= w_next;
        r400_reg <= r400_next;
        err_reg  <= err_next;
        if (emit)
        begin
            out_year_reg  <= y_reg[cdow_pkg::YEAR_W-1:0];
            out_month_reg <= m_reg;
            out_day_reg   <= s_reg[cdow_pkg::DAY_W-1:0];
            out_leap_reg  <= leap;
            out_wday_reg  <= w_reg[cdow_pkg::WDAY_W-1:0];
            out_err_reg   <= err_reg;
        end
    end

    assign in_stall     = !ctrl.idle;
    assign out_valid    = out_valid_reg;
    assign out_year     = out_year_reg;
    assign out_month    = out_month_reg;
    assign out_day      = out_day_reg;
    assign is_leap_year = out_leap_reg;
    assign weekday      = out_wday_reg;
    assign range_error  = out_err_reg;

endmodule

// File: rtl/cdow_seq.sv
`timescale 1ns / 1ps
// Microprogram sequencer: control store, step counter and conditional jumps.
module cdow_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  cdow_pkg::status_t status,
    output cdow_pkg::ctrl_t   ctrl
);

    typedef struct packed {
        cdow_pkg::op_t                op;
        cdow_pkg::cond_t              cond;
        logic [cdow_pkg::UPC_W-1:0]   target;
    } uword_t;

    localparam logic [cdow_pkg::UPC_W-1:0] A_IDLE    = 4'd0;
    localparam logic [cdow_pkg::UPC_W-1:0] A_MOD400  = 4'd1;
    localparam logic [cdow_pkg::UPC_W-1:0] A_SETLEAP = 4'd2;
    localparam logic [cdow_pkg::UPC_W-1:0] A_CHECK   = 4'd3;
    localparam logic [cdow_pkg::UPC_W-1:0] A_ADDOFF  = 4'd4;
    localparam logic [cdow_pkg::UPC_W-1:0] A_FWD     = 4'd5;
    localparam logic [cdow_pkg::UPC_W-1:0] A_BWD     = 4'd6;
    localparam logic [cdow_pkg::UPC_W-1:0] A_RANGE   = 4'd7;
    localparam logic [cdow_pkg::UPC_W-1:0] A_ZPREP   = 4'd8;
    localparam logic [cdow_pkg::UPC_W-1:0] A_DIV100  = 4'd9;
    localparam logic [cdow_pkg::UPC_W-1:0] A_ZSUM1   = 4'd10;
    localparam logic [cdow_pkg::UPC_W-1:0] A_ZSUM2   = 4'd11;
    localparam logic [cdow_pkg::UPC_W-1:0] A_MOD7    = 4'd12;
    localparam logic [cdow_pkg::UPC_W-1:0] A_EMIT    = 4'd13;
    localparam logic [cdow_pkg::UPC_W-1:0] A_RETRY   = 4'd14;

    function automatic uword_t ucode(input logic [cdow_pkg::UPC_W-1:0] addr);
        uword_t w;
        case (addr)
            A_IDLE:    w = '{op: cdow_pkg::OP_LOAD,     cond: cdow_pkg::C_NO_IN,
                             target: A_IDLE};
            A_MOD400:  w = '{op: cdow_pkg::OP_SUB400,   cond: cdow_pkg::C_T_GE400,
                             target: A_MOD400};
            A_SETLEAP: w = '{op: cdow_pkg::OP_SET_LEAP, cond: cdow_pkg::C_NEVER,
                             target: A_IDLE};
            A_CHECK:   w = '{op: cdow_pkg::OP_CHECK,    cond: cdow_pkg::C_NEVER,
                             target: A_IDLE};
            A_ADDOFF:  w = '{op: cdow_pkg::OP_ADD_OFF,  cond: cdow_pkg::C_NEVER,
                             target: A_IDLE};
            A_FWD:     w = '{op: cdow_pkg::OP_FWD,      cond: cdow_pkg::C_S_GT_MLEN,
                             target: A_FWD};
            A_BWD:     w = '{op: cdow_pkg::OP_BWD,      cond: cdow_pkg::C_S_LT1,
                             target: A_BWD};
            A_RANGE:   w = '{op: cdow_pkg::OP_RANGE,    cond: cdow_pkg::C_NEVER,
                             target: A_IDLE};
            A_ZPREP:   w = '{op: cdow_pkg::OP_ZPREP,    cond: cdow_pkg::C_NEVER,
                             target: A_IDLE};
            A_DIV100:  w = '{op: cdow_pkg::OP_SUB100,   cond: cdow_pkg::C_T_GE100,
                             target: A_DIV100};
            A_ZSUM1:   w = '{op: cdow_pkg::OP_ZSUM1,    cond: cdow_pkg::C_NEVER,
                             target: A_IDLE};
            A_ZSUM2:   w = '{op: cdow_pkg::OP_ZSUM2,    cond: cdow_pkg::C_NEVER,
                             target: A_IDLE};
            A_MOD7:    w = '{op: cdow_pkg::OP_SUB7,     cond: cdow_pkg::C_W_GE7,
                             target: A_MOD7};
            A_EMIT:    w = '{op: cdow_pkg::OP_EMIT,     cond: cdow_pkg::C_OUT_FREE,
                             target: A_IDLE};
            A_RETRY:   w = '{op: cdow_pkg::OP_NOP,      cond: cdow_pkg::C_ALWAYS,
                             target: A_EMIT};
            default:   w = '{op: cdow_pkg::OP_NOP,      cond: cdow_pkg::C_ALWAYS,
                             target: A_IDLE};
        endcase
        return w;
    endfunction

    logic [cdow_pkg::UPC_W-1:0] upc_reg;
    logic [cdow_pkg::UPC_W-1:0] upc_next;
    uword_t                     uw;
    logic                       take;

    always_comb
    begin
        uw = ucode(upc_reg);
        case (uw.cond)
            cdow_pkg::C_NEVER:     take = 1'b0;
            cdow_pkg::C_ALWAYS:    take = 1'b1;
            cdow_pkg::C_NO_IN:     take = status.no_in;
            cdow_pkg::C_T_GE400:   take = status.t_ge400;
            cdow_pkg::C_S_GT_MLEN: take = status.s_gt_mlen;
            cdow_pkg::C_S_LT1:     take = status.s_lt1;
            cdow_pkg::C_T_GE100:   take = status.t_ge100;
            cdow_pkg::C_W_GE7:     take = status.w_ge7;
            cdow_pkg::C_OUT_FREE:  take = status.out_free;
            default:               take = 1'b0;
        endcase
        upc_next  = take ? uw.target : upc_reg + 4'd1;
        ctrl.op   = uw.op;
        ctrl.idle = (upc_reg == A_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= A_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: rtl/cdow_check.sv
`timescale 1ns / 1ps
// Port-level assertion checker for the date offset block, with its bind.
module cdow_check
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [cdow_pkg::YEAR_W-1:0]   out_year,
    input logic [cdow_pkg::MONTH_W-1:0]  out_month,
    input logic [cdow_pkg::DAY_W-1:0]    out_day,
    input logic                          is_leap_year,
    input logic [cdow_pkg::WDAY_W-1:0]   weekday,
    input logic                          range_error
);

    a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_month >= cdow_pkg::MONTH_JAN) &&
                      (out_month <= cdow_pkg::MONTH_DEC) &&
                      (out_day >= cdow_pkg::DAY_FIRST) && (weekday <= 3'd6))
        else $error("result month, day or weekday out of range");

    a_error_default: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (out_year == cdow_pkg::YEAR_DEFAULT) &&
                                       (out_month == cdow_pkg::MONTH_JAN) &&
                                       (out_day == cdow_pkg::DAY_FIRST) &&
                                       (weekday == cdow_pkg::WDAY_MONDAY) && !is_leap_year)
        else $error("range error result is not the default date");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !range_error) |-> (out_year >= 14'd1) &&
                                        (out_year <= cdow_pkg::YEAR_MAX))
        else $error("result year outside range without range_error");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(out_year) &&
                                     $stable(out_month) && $stable(out_day) &&
                                     $stable(weekday) && $stable(range_error))
        else $error("stalled result changed");

endmodule

bind calendar_date_offset_weekday cdow_check u_cdow_check
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .is_leap_year (is_leap_year),
    .weekday      (weekday),
    .range_error  (range_error)
);

// File: tb/tb_calendar_date_offset_weekday.sv
`timescale 1ns / 1ps
// Self-checking testbench for the calendar date offset and weekday block.
module tb_calendar_date_offset_weekday;

    localparam int OFF_W        = cdow_pkg::OFFSET_BITS_DEF;
    localparam int YEAR_W       = cdow_pkg::YEAR_W;
    localparam int MONTH_W      = cdow_pkg::MONTH_W;
    localparam int DAY_W        = cdow_pkg::DAY_W;
    localparam int WDAY_W       = cdow_pkg::WDAY_W;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int TAIL_CYCLES  = 1400;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               leap;
        logic [WDAY_W-1:0]  wday;
        logic               range_err;
    } dated_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [YEAR_W-1:0]       in_year = '0;
    logic [MONTH_W-1:0]      in_month = '0;
    logic [DAY_W-1:0]        in_day = '0;
    logic signed [OFF_W-1:0] day_offset = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [YEAR_W-1:0]       out_year;
    logic [MONTH_W-1:0]      out_month;
    logic [DAY_W-1:0]        out_day;
    logic                    is_leap_year;
    logic [WDAY_W-1:0]       weekday;
    logic                    range_error;

    dated_result_t pending_dates[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            hold_request = 0;
    bit            tx_idle_en = 1'b1;
    bit            rx_idle_en = 1'b1;

    calendar_date_offset_weekday DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_year      (in_year),
        .in_month     (in_month),
        .in_day       (in_day),
        .day_offset   (day_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_year     (out_year),
        .out_month    (out_month),
        .out_day      (out_day),
        .is_leap_year (is_leap_year),
        .weekday      (weekday),
        .range_error  (range_error)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_calendar_date_offset_weekday: FAIL");
            $finish;
        end
    end

    function automatic bit leap_year(input int y);
        int r;
        r = ((y % 400) + 400) % 400;
        return (r == 0) || ((r % 4 == 0) && (r % 100 != 0));
    endfunction

    function automatic int days_in_month(input int m, input int y);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic int zeller_weekday(input int y, input int m, input int d);
        int c;
        int yy;
        int mm;
        int w;
        if (m <= 2)
        begin
            c  = (y - 1) / 100;
            yy = (y - 1) % 100;
            mm = m + 12;
        end
        else
        begin
            c  = y / 100;
            yy = y % 100;
            mm = m;
        end
        w = yy + yy / 4 + c / 4 - 2 * c + 26 * (mm + 1) / 10 + d - 1;
        return ((w % 7) + 7) % 7;
    endfunction

    function automatic dated_result_t predict_shifted_date(input int y, input int m,
                                                           input int d, input int off);
        dated_result_t r;
        int            sum;
        bit            err;
        if (y < 1 || m < 1 || m > 12 || d < 1 || (m == 2 && d > days_in_month(2, y)))
        begin
            y = 1900;
            m = 1;
            d = 1;
        end
        sum = off + d;
        while (sum > days_in_month(m, y))
        begin
            sum -= days_in_month(m, y);
            m++;
            if (m > 12)
            begin
                m = 1;
                y++;
            end
        end
        while (sum < 1)
        begin
            m--;
            if (m < 1)
            begin
                m = 12;
                y--;
            end
            sum += days_in_month(m, y);
        end
        d = sum;
        err = (y < 1 || y > 9999);
        if (err)
        begin
            y = 1900;
            m = 1;
            d = 1;
        end
        r.year      = YEAR_W'(y);
        r.month     = MONTH_W'(m);
        r.day       = DAY_W'(d);
        r.leap      = leap_year(y);
        r.wday      = WDAY_W'(zeller_weekday(y, m, d));
        r.range_err = err;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        dated_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %0d-%0d-%0d",
                         $time, out_year, out_month, out_day);
                mismatch_count++;
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("out_year", want.year, out_year);
                check_field("out_month", want.month, out_month);
                check_field("out_day", want.day, out_day);
                check_field("is_leap_year", want.leap, is_leap_year);
                check_field("weekday", want.wday, weekday);
                check_field("range_error", want.range_err, range_error);
            end
        end
    end

    initial
    begin : result_receiver
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rst_n && out_valid && !out_stall && rx_idle_en)
            begin
                n = $urandom_range(0, 11);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic offer_date(input int year, input int month, input int day, input int offset);
        int                      gap;
        logic [YEAR_W-1:0]       yv;
        logic [MONTH_W-1:0]      mv;
        logic [DAY_W-1:0]        dv;
        logic signed [OFF_W-1:0] ov;
        int                      off_i;
        yv    = YEAR_W'(year);
        mv    = MONTH_W'(month);
        dv    = DAY_W'(day);
        ov    = OFF_W'(offset);
        off_i = ov;
        gap   = tx_idle_en ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_year    <= yv;
        in_month   <= mv;
        in_day     <= dv;
        day_offset <= ov;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_dates.push_back(predict_shifted_date(yv, mv, dv, off_i));
    endtask

    task automatic offer_random_date();
        int kind;
        int y;
        int m;
        int d;
        int off;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 2) == 0)
            off = int'($urandom_range(0, 65535)) - 32768;
        else
            off = int'($urandom_range(0, 4000)) - 2000;
        if (kind == 0)
        begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
        else if (kind == 1)
        begin
            y = $urandom_range(1, 9999);
            m = 2;
            d = $urandom_range(28, 31);
        end
        else
        begin
            if (kind == 2)
                y = $urandom_range(10000, 16383);
            else if (kind == 3)
                y = $urandom_range(0, 1) ? $urandom_range(1, 90) : $urandom_range(9910, 9999);
            else
                y = $urandom_range(1, 9999);
            m = $urandom_range(1, 12);
            d = $urandom_range(1, days_in_month(m, y));
        end
        offer_date(y, m, d, off);
    endtask

    task automatic test_directed_dates();
        offer_date(2024, 2, 29, 0);
        offer_date(2023, 2, 29, 0);
        offer_date(1900, 2, 29, 5);
        offer_date(2000, 2, 29, 0);
        offer_date(0, 5, 5, 10);
        offer_date(2020, 0, 10, 0);
        offer_date(2020, 13, 10, 0);
        offer_date(2020, 15, 31, 0);
        offer_date(2020, 6, 0, 3);
        offer_date(2021, 4, 31, 0);
        offer_date(1, 1, 1, -1);
        offer_date(9999, 12, 31, 1);
        offer_date(9999, 12, 31, 0);
        offer_date(1, 1, 1, 0);
        offer_date(16383, 12, 31, -32768);
        offer_date(10050, 6, 15, -32768);
        offer_date(2000, 1, 1, 32767);
        offer_date(2000, 1, 1, -32768);
        offer_date(1999, 12, 31, 1);
        offer_date(2000, 3, 1, -1);
        offer_date(1, 1, 1, 32767);
        offer_date(9999, 12, 31, -32768);
        offer_date(10922, 10, 21, -31);
    endtask

    task automatic test_random_dates(input int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count) offer_random_date();
    endtask

    task automatic test_back_to_back(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) offer_random_date();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure();
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (12)
            offer_date($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 28),
                       $urandom_range(0, 5));
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        repeat (20) offer_random_date();
        in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (20) offer_random_date();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_dates();
        test_random_dates(200);
        test_back_to_back(100);
        test_output_backpressure();
        test_pause_until_drained();
        test_random_dates(165);
        in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("tb_calendar_date_offset_weekday: PASS");
        else
            $display("tb_calendar_date_offset_weekday: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/cdow_pkg.sv
rtl/cdow_seq.sv
rtl/calendar_date_offset_weekday.sv
rtl/cdow_check.sv
tb/tb_calendar_date_offset_weekday.sv
